@@ design/lkv_pkg.sv @@
`timescale 1ns / 1ps

package lkv_pkg;

    localparam int DATA_W = 32;
    localparam int CFG_W  = 5;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // request opcodes
    localparam logic ACT_GET = 1'b0;
    localparam logic ACT_SET = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_VREAD = 4'b0100,
        ST_APPLY = 4'b1000
    } state_t;

endpackage

@@ design/lkv_ram.sv @@
`timescale 1ns / 1ps

// simple dual-port RAM, one write, one registered read
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/lru_key_value_cache.sv @@
`timescale 1ns / 1ps

// Fully associative key-value cache with least-recently-used replacement.
// A request is a get (action 0) or a set (action 1) of a 32-bit key; each
// request yields exactly one response with found, read_value, evicted and
// evicted_key. Keys and values live in two RAMs; valid bits, recency ranks
// (0 = most recent) and the fill count are flip-flops, so the store is
// empty right after reset and after every write of the capacity register,
// with no clearing pass. From acceptance to the response register a
// request passes through the scan, in which the single key comparator
// sweeps the key RAM one entry per cycle, then a read of the hit entry's
// value, then the store update, which waits while the output register
// still holds an unaccepted response. in_ready is high only between
// requests, so a new request is accepted only after the previous one
// has updated the store; a finished response may wait in the output
// register while the next request is accepted and scanned.
// A capacity of 0 behaves as 1, values above CAPACITY saturate to it.
// Write the capacity register only while no request is in flight.
module lru_key_value_cache
    import lkv_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_write_en,
    input  logic [CFG_W-1:0]         cfg_write_data,

    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     action,
    input  logic signed [DATA_W-1:0] key,
    input  logic signed [DATA_W-1:0] value,

    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     found,
    output logic signed [DATA_W-1:0] read_value,
    output logic                     evicted,
    output logic signed [DATA_W-1:0] evicted_key
);

    localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int RW   = IW;
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int EW   = (CNTW > CFG_W) ? CNTW : CFG_W;
    localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

    // sequencer
    state_t state_reg, state_next;
    logic [IW-1:0] scan_reg, scan_next;

    // latched request
    logic              act_reg;
    logic [DATA_W-1:0] key_reg;
    logic [DATA_W-1:0] val_reg;

    // scan results
    logic              hit_reg, hit_next;
    logic [IW-1:0]     hit_slot_reg, hit_slot_next;
    logic [RW-1:0]     hit_rank_reg, hit_rank_next;
    logic              any_reg, any_next;
    logic [IW-1:0]     best_idx_reg, best_idx_next;
    logic [RW-1:0]     best_rank_reg, best_rank_next;
    logic [DATA_W-1:0] best_key_reg, best_key_next;
    logic              free_found_reg, free_found_next;
    logic [IW-1:0]     free_idx_reg, free_idx_next;

    // store bookkeeping
    logic [CAPACITY-1:0] valid_reg, valid_next;
    logic [RW-1:0]       rank_reg [CAPACITY];
    logic [RW-1:0]       rank_next [CAPACITY];
    logic [CNTW-1:0]     count_reg, count_next;
    logic [CFG_W-1:0]    cap_reg;

    // response register
    logic              out_valid_reg;
    logic              found_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic              evicted_reg;
    logic [DATA_W-1:0] evicted_key_reg;

    // RAM ports
    logic [IW-1:0]     key_raddr;
    logic [DATA_W-1:0] key_rdata;
    logic              key_we;
    logic [IW-1:0]     key_waddr;
    logic [DATA_W-1:0] val_rdata;
    logic              val_we;
    logic [IW-1:0]     val_waddr;

    logic              in_fire;
    logic              apply_go;
    logic [EW-1:0]     cap_eff;
    logic              do_evict;
    logic [IW-1:0]     ins_slot;
    logic              cur_valid;
    logic [RW-1:0]     cur_rank;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign apply_go = (state_reg == ST_APPLY) && (!out_valid_reg || out_ready);

    // effective capacity: zero acts as one, saturate at CAPACITY
    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = EW'(1);
        end
        else if (EW'(cap_reg) > EW'(CAPACITY))
        begin
            cap_eff = EW'(CAPACITY);
        end
        else
        begin
            cap_eff = EW'(cap_reg);
        end
    end

    assign do_evict = (EW'(count_reg) >= cap_eff);

    // lowest free slot once the victim has been dropped
    assign ins_slot = (do_evict && !(free_found_reg && (free_idx_reg < best_idx_reg)))
                      ? best_idx_reg : free_idx_reg;

    // key RAM read runs one entry ahead of the compare
    assign key_raddr = ((state_reg == ST_SCAN) && (scan_reg != LAST))
                       ? scan_reg + 1'b1 : '0;

    assign cur_valid = valid_reg[scan_reg];
    assign cur_rank  = rank_reg[scan_reg];

    // sequencer and scan tracking
    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        hit_next        = hit_reg;
        hit_slot_next   = hit_slot_reg;
        hit_rank_next   = hit_rank_reg;
        any_next        = any_reg;
        best_idx_next   = best_idx_reg;
        best_rank_next  = best_rank_reg;
        best_key_next   = best_key_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next      = ST_SCAN;
                    scan_next       = '0;
                    hit_next        = 1'b0;
                    hit_slot_next   = '0;
                    any_next        = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            ST_SCAN:
            begin
                if (cur_valid && (key_rdata == key_reg))
                begin
                    hit_next      = 1'b1;
                    hit_slot_next = scan_reg;
                    hit_rank_next = cur_rank;
                end
                if (cur_valid && (!any_reg || (cur_rank > best_rank_reg)))
                begin
                    any_next       = 1'b1;
                    best_idx_next  = scan_reg;
                    best_rank_next = cur_rank;
                    best_key_next  = key_rdata;
                end
                if (!cur_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = scan_reg;
                end
                if (scan_reg == LAST)
                begin
                    state_next = ST_VREAD;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_VREAD:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (apply_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // store update at the end of a request
    always_comb
    begin
        valid_next = valid_reg;
        rank_next  = rank_reg;
        count_next = count_reg;
        key_we     = 1'b0;
        key_waddr  = ins_slot;
        val_we     = 1'b0;
        val_waddr  = ins_slot;

        if (apply_go)
        begin
            if (hit_reg)
            begin
                // promote: age the entries newer than the hit one
                for (int j = 0; j < CAPACITY; j++)
                begin
                    if (valid_reg[j] && (rank_reg[j] < hit_rank_reg))
                    begin
                        rank_next[j] = rank_reg[j] + 1'b1;
                    end
                end
                rank_next[hit_slot_reg] = '0;
                if (act_reg == ACT_SET)
                begin
                    val_we    = 1'b1;
                    val_waddr = hit_slot_reg;
                end
            end
            else if (act_reg == ACT_SET)
            begin
                for (int j = 0; j < CAPACITY; j++)
                begin
                    if (do_evict && (IW'(j) == best_idx_reg))
                    begin
                        valid_next[j] = 1'b0;
                    end
                    else if (valid_reg[j])
                    begin
                        rank_next[j] = rank_reg[j] + 1'b1;
                    end
                end
                valid_next[ins_slot] = 1'b1;
                rank_next[ins_slot]  = '0;
                if (!do_evict)
                begin
                    count_next = count_reg + 1'b1;
                end
                key_we = 1'b1;
                val_we = 1'b1;
            end
        end

        if (cfg_write_en)
        begin
            valid_next = '0;
            count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < CAPACITY; j++)
            begin
                rank_reg[j] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            rank_reg  <= rank_next;
            if (cfg_write_en)
            begin
                cap_reg <= cfg_write_data;
            end
            if (apply_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg       <= scan_next;
        hit_reg        <= hit_next;
        hit_slot_reg   <= hit_slot_next;
        hit_rank_reg   <= hit_rank_next;
        any_reg        <= any_next;
        best_idx_reg   <= best_idx_next;
        best_rank_reg  <= best_rank_next;
        best_key_reg   <= best_key_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        if (in_fire)
        begin
            act_reg <= action;
            key_reg <= key;
            val_reg <= value;
        end
        if (apply_go)
        begin
            found_reg       <= hit_reg;
            read_value_reg  <= (hit_reg && (act_reg == ACT_GET)) ? val_rdata : '0;
            evicted_reg     <= !hit_reg && (act_reg == ACT_SET) && do_evict;
            evicted_key_reg <= (!hit_reg && (act_reg == ACT_SET) && do_evict)
                               ? best_key_reg : '0;
        end
    end

    lkv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_reg),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    lkv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (val_waddr),
        .wdata (val_reg),
        .raddr (hit_slot_reg),
        .rdata (val_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign found       = found_reg;
    assign read_value  = read_value_reg;
    assign evicted     = evicted_reg;
    assign evicted_key = evicted_key_reg;

    // fill count tracks the valid bits
    a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("fill count out of step with valid bits");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= CAPACITY)
        else $error("fill count above capacity");

    // an accepted request starts its sweep at entry zero
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_SCAN) && (scan_reg == '0))
        else $error("scan did not start at entry zero");

    // eviction only on a set miss
    a_evict_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted) |-> !found)
        else $error("eviction reported on a hit");

    a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (read_value != '0)) |-> found)
        else $error("read value on a miss");

endmodule
